[rtl/pohd_pkg.sv]
`default_nettype none
package pohd_pkg;

	localparam int OFFSET_BITS_DEF = 40;
	localparam int NAME_BYTES_DEF  = 20;
	localparam int SIZE_W          = 64;
	localparam int SHIFT_W         = 7;

	localparam logic [SHIFT_W-1:0] SIZE_SHIFT_INIT = 7'd4;
	localparam logic [SHIFT_W-1:0] SIZE_SHIFT_STEP = 7'd7;

	localparam logic [1:0] KIND_HDR  = 2'd0;
	localparam logic [1:0] KIND_NAME = 2'd1;
	localparam logic [1:0] KIND_ERR  = 2'd2;

	localparam logic [1:0] ERR_NONE  = 2'd0;
	localparam logic [1:0] ERR_TYPE  = 2'd1;
	localparam logic [1:0] ERR_TRUNC = 2'd2;
	localparam logic [1:0] ERR_RANGE = 2'd3;

	localparam logic [2:0] TYPE_COMMIT = 3'd0;
	localparam logic [2:0] TYPE_TREE   = 3'd1;
	localparam logic [2:0] TYPE_BLOB   = 3'd2;
	localparam logic [2:0] TYPE_TAG    = 3'd3;
	localparam logic [2:0] TYPE_OFS    = 3'd4;
	localparam logic [2:0] TYPE_REF    = 3'd5;

	localparam logic [2:0] PACK_COMMIT = 3'd1;
	localparam logic [2:0] PACK_TREE   = 3'd2;
	localparam logic [2:0] PACK_BLOB   = 3'd3;
	localparam logic [2:0] PACK_TAG    = 3'd4;
	localparam logic [2:0] PACK_OFS    = 3'd6;
	localparam logic [2:0] PACK_REF    = 3'd7;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_SIZE,
		PH_OFS_FIRST,
		PH_OFS_MORE,
		PH_NAME
	} phase_t;

	typedef struct packed {
		logic       bad;
		logic [2:0] obj_type;
	} type_map_t;

	function automatic type_map_t map_type(input logic [2:0] code);
		type_map_t m;
		m.bad      = 1'b0;
		m.obj_type = TYPE_COMMIT;
		unique case (code)
			PACK_COMMIT: m.obj_type = TYPE_COMMIT;
			PACK_TREE:   m.obj_type = TYPE_TREE;
			PACK_BLOB:   m.obj_type = TYPE_BLOB;
			PACK_TAG:    m.obj_type = TYPE_TAG;
			PACK_OFS:    m.obj_type = TYPE_OFS;
			PACK_REF:    m.obj_type = TYPE_REF;
			default:     m.bad = 1'b1;
		endcase
		return m;
	endfunction

endpackage
`default_nettype wire

[rtl/pack_object_header_decoder.sv]
// Path: an accepted word sits in the input register; its result is then loaded into
//   the result register once that register can advance, and is offered from there.
// Throughput: one header byte per cycle; the decode step is a single pass between the two.
//   A stalled result holds both registers and stalls the input.
// Reset: arst_n clears the valid flags and the decode state; the decoder starts idle.
`default_nettype none
module pack_object_header_decoder
	import pohd_pkg::*;
#(
	parameter int OFFSET_BITS = OFFSET_BITS_DEF,
	parameter int NAME_BYTES  = NAME_BYTES_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,

	input  wire logic                   item_valid,
	output logic                        item_stall,
	input  wire logic                   start_flag,
	input  wire logic [OFFSET_BITS-1:0] position,
	input  wire logic [7:0]             data_byte,

	output logic                        result_valid,
	input  wire logic                   result_stall,
	output logic [1:0]                  result_kind,
	output logic [2:0]                  obj_type,
	output logic [SIZE_W-1:0]           object_size,
	output logic [OFFSET_BITS-1:0]      base_offset,
	output logic [7:0]                  name_byte,
	output logic [1:0]                  error_code,
	output logic                        last
);

	localparam int CNT_W = $clog2(NAME_BYTES + 1);
	localparam int OB    = OFFSET_BITS;

	logic                 valid_s1;
	logic                 start_s1;
	logic [OB-1:0]        pos_s1;
	logic [7:0]           byte_s1;
	logic                 adv_s1;

	phase_t               phase_q, phase_d;
	logic [2:0]           type_q, type_d;
	logic [SIZE_W-1:0]    size_q, size_d;
	logic [SHIFT_W-1:0]   shift_q, shift_d;
	logic [OB-1:0]        back_q, back_d;
	logic [OB-1:0]        ostart_q, ostart_d;
	logic [CNT_W-1:0]     cnt_q, cnt_d;

	logic                 hit;
	logic [1:0]           r_kind;
	logic [2:0]           r_type;
	logic [SIZE_W-1:0]    r_size;
	logic [OB-1:0]        r_base;
	logic [7:0]           r_name;
	logic [1:0]           r_err;
	logic                 r_last;

	logic                 res_valid_q;
	logic [1:0]           kind_q;
	logic [2:0]           otype_q;
	logic [SIZE_W-1:0]    osize_q;
	logic [OB-1:0]        base_q;
	logic [7:0]           name_q;
	logic [1:0]           err_q;
	logic                 last_q;

	assign adv_s1     = !res_valid_q || !result_stall;
	assign item_stall = valid_s1 && !adv_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!item_stall && item_valid) begin
			start_s1 <= start_flag;
			pos_s1   <= position;
			byte_s1  <= data_byte;
		end
	end

	// decode state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			type_q   <= TYPE_COMMIT;
			size_q   <= '0;
			shift_q  <= SIZE_SHIFT_INIT;
			back_q   <= '0;
			ostart_q <= '0;
			cnt_q    <= '0;
		end else if (valid_s1 && adv_s1) begin
			phase_q  <= phase_d;
			type_q   <= type_d;
			size_q   <= size_d;
			shift_q  <= shift_d;
			back_q   <= back_d;
			ostart_q <= ostart_d;
			cnt_q    <= cnt_d;
		end
	end

	always_comb begin
		type_map_t        tm;
		logic             done;
		logic [6:0]       bits;
		logic [SIZE_W+6:0] sh_wide;
		logic [OB:0]      t_inc;
		logic [OB-1:0]    back_new;
		logic             ofs_ok;

		phase_d  = phase_q;
		type_d   = type_q;
		size_d   = size_q;
		shift_d  = shift_q;
		back_d   = back_q;
		ostart_d = ostart_q;
		cnt_d    = cnt_q;

		hit    = 1'b0;
		r_kind = KIND_HDR;
		r_type = TYPE_COMMIT;
		r_size = '0;
		r_base = '0;
		r_name = '0;
		r_err  = ERR_NONE;
		r_last = 1'b0;

		done     = 1'b0;
		bits     = byte_s1[6:0];
		tm       = map_type(byte_s1[6:4]);
		sh_wide  = {{SIZE_W{1'b0}}, bits} << shift_q[5:0];
		t_inc    = {1'b0, back_q} + {{OB{1'b0}}, 1'b1};
		back_new = {t_inc[OB-8:0], bits};
		ofs_ok   = 1'b1;

		if (start_s1) begin
			ostart_d = pos_s1;
			type_d   = tm.obj_type;
			size_d   = {{(SIZE_W-4){1'b0}}, byte_s1[3:0]};
			shift_d  = SIZE_SHIFT_INIT;
			back_d   = '0;
			cnt_d    = '0;
			if (tm.bad) begin
				type_d  = TYPE_COMMIT;
				phase_d = PH_IDLE;
				hit     = 1'b1;
				r_kind  = KIND_ERR;
				r_err   = ERR_TYPE;
				r_last  = 1'b1;
			end else if (byte_s1[7]) begin
				phase_d = PH_SIZE;
			end else begin
				done = 1'b1;
			end
		end else begin
			unique case (phase_q) inside
				PH_SIZE: begin
					if (shift_q[6] || (sh_wide[SIZE_W+6:SIZE_W] != '0)) begin
						phase_d = PH_IDLE;
						hit     = 1'b1;
						r_kind  = KIND_ERR;
						r_err   = ERR_RANGE;
						r_last  = 1'b1;
					end else begin
						size_d  = size_q | sh_wide[SIZE_W-1:0];
						shift_d = shift_q + SIZE_SHIFT_STEP;
						done    = !byte_s1[7];
					end
				end
				PH_OFS_FIRST, PH_OFS_MORE: begin
					if (phase_q == PH_OFS_FIRST) begin
						back_new = {{(OB-7){1'b0}}, bits};
						phase_d  = PH_OFS_MORE;
					end else if (t_inc[OB:OB-7] != '0) begin
						ofs_ok = 1'b0;
					end
					if (ofs_ok) begin
						back_d = back_new;
						if (!byte_s1[7]) begin
							if (back_new == '0 || back_new > ostart_q) begin
								ofs_ok = 1'b0;
							end else begin
								phase_d = PH_IDLE;
								hit     = 1'b1;
								r_type  = type_q;
								r_size  = size_q;
								r_base  = ostart_q - back_new;
								r_last  = 1'b1;
							end
						end
					end
					if (!ofs_ok) begin
						phase_d = PH_IDLE;
						hit     = 1'b1;
						r_kind  = KIND_ERR;
						r_err   = ERR_RANGE;
						r_last  = 1'b1;
					end
				end
				PH_NAME: begin
					cnt_d  = cnt_q + CNT_W'(1);
					r_last = (cnt_q >= CNT_W'(NAME_BYTES - 1));
					if (r_last) begin
						phase_d = PH_IDLE;
					end
					hit    = 1'b1;
					r_kind = KIND_NAME;
					r_type = type_q;
					r_size = size_q;
					r_name = byte_s1;
				end
				default: begin
				end
			endcase
		end

		if (done) begin
			if (type_d == TYPE_OFS) begin
				phase_d = PH_OFS_FIRST;
				back_d  = '0;
			end else if (type_d == TYPE_REF) begin
				phase_d = PH_NAME;
				cnt_d   = '0;
				hit     = 1'b1;
				r_type  = type_d;
				r_size  = size_d;
			end else begin
				phase_d = PH_IDLE;
				hit     = 1'b1;
				r_type  = type_d;
				r_size  = size_d;
				r_last  = 1'b1;
			end
		end

		// drop the new header's own result, report the cut-short one
		if (start_s1 && phase_q != PH_IDLE) begin
			hit    = 1'b1;
			r_kind = KIND_ERR;
			r_type = TYPE_COMMIT;
			r_size = '0;
			r_base = '0;
			r_name = '0;
			r_err  = ERR_TRUNC;
			r_last = 1'b1;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv_s1) begin
			res_valid_q <= valid_s1 && hit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && valid_s1 && hit) begin
			kind_q  <= r_kind;
			otype_q <= r_type;
			osize_q <= r_size;
			base_q  <= r_base;
			name_q  <= r_name;
			err_q   <= r_err;
			last_q  <= r_last;
		end
	end

	assign result_valid = res_valid_q;
	assign result_kind  = kind_q;
	assign obj_type     = otype_q;
	assign object_size  = osize_q;
	assign base_offset  = base_q;
	assign name_byte    = name_q;
	assign error_code   = err_q;
	assign last         = last_q;

	a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> (result_valid && result_stall))
		else $error("input stalled while result side free");

	a_err_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_kind == KIND_ERR) |-> (last && error_code != ERR_NONE
			&& object_size == '0 && base_offset == '0))
		else $error("error word malformed");

	a_name_type: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_kind == KIND_NAME) |-> (obj_type == TYPE_REF))
		else $error("name word without reference delta type");

	a_hold_fresh: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall) |=> (result_valid && $stable(result_kind)
			&& $stable(object_size) && $stable(last)))
		else $error("stalled result changed");

endmodule
`default_nettype wire
